FILE: sv/sefd_pkg.sv
// Shared types and constants for the serial event frame decoder.
// No dependencies; used by sefd_event_map and serial_event_frame_decoder.
`default_nettype none

package sefd_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] REG_SYNC   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_LINK   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_CALL   = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_PLAYER = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_VOLUME = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_TRACK  = 3'd5;

  localparam logic [3:0] EV_CONNECTED    = 4'd0;
  localparam logic [3:0] EV_DISCONNECTED = 4'd1;
  localparam logic [3:0] EV_INCOMING     = 4'd2;
  localparam logic [3:0] EV_OUTGOING     = 4'd3;
  localparam logic [3:0] EV_REJECTED     = 4'd4;
  localparam logic [3:0] EV_PLAYPAUSE    = 4'd5;
  localparam logic [3:0] EV_MUTE         = 4'd6;
  localparam logic [3:0] EV_VOL_UP       = 4'd7;
  localparam logic [3:0] EV_VOL_DOWN     = 4'd8;
  localparam logic [3:0] EV_TRACK        = 4'd9;

  localparam logic [7:0] PARAM_CONNECTED = 8'h01;
  localparam logic [7:0] CALL_ST_END     = 8'h00;
  localparam logic [7:0] CALL_ST_IN      = 8'h02;
  localparam logic [7:0] CALL_ST_OUT     = 8'h03;
  localparam logic [7:0] CALL_ST_ACTIVE  = 8'h04;
  localparam logic [7:0] PLAY_ST_A       = 8'h01;
  localparam logic [7:0] PLAY_ST_B       = 8'h02;
  localparam logic [7:0] VOL_MIN         = 8'h00;
  localparam logic [7:0] VOL_RESET       = 8'hFF;

  typedef enum logic [1:0] {
    CPH_IDLE    = 2'd0,
    CPH_RINGING = 2'd1,
    CPH_DIALING = 2'd2,
    CPH_TALKING = 2'd3
  } call_phase_t;

  typedef struct packed {
    logic [15:0] link;
    logic [15:0] call;
    logic [15:0] player;
    logic [15:0] volume;
    logic [15:0] track;
  } opcodes_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic [7:0]  p_first;
    logic [7:0]  p_second;
    logic [7:0]  p_seventh;
    logic        has_one;
    logic        has_two;
    logic        has_seven;
  } frame_t;

  typedef struct packed {
    call_phase_t call_phase;
    logic [7:0]  last_volume;
    logic        baselined;
  } ctx_t;

endpackage

`default_nettype wire

FILE: sv/sefd_event_map.sv
// Maps one checked frame to at most one event and the next call/volume context.
// Depends on sefd_pkg.
`default_nettype none

module sefd_event_map
  import sefd_pkg::*;
(
  input  var frame_t     frame,
  input  var opcodes_t   opcodes,
  input  var ctx_t       ctx,
  output logic           ev,
  output logic [3:0]     code,
  output ctx_t           ctx_next
);

  always_comb begin
    ev       = 1'b0;
    code     = EV_CONNECTED;
    ctx_next = ctx;
    if (frame.opcode == opcodes.link) begin
      if (frame.has_one) begin
        ev   = 1'b1;
        code = (frame.p_first == PARAM_CONNECTED) ? EV_CONNECTED : EV_DISCONNECTED;
        ctx_next.last_volume = VOL_RESET;
        ctx_next.baselined   = 1'b0;
        ctx_next.call_phase  = CPH_IDLE;
      end
    end else if (frame.opcode == opcodes.call) begin
      if (frame.has_two) begin
        if (frame.p_second == CALL_ST_IN) begin
          ctx_next.call_phase = CPH_RINGING;
          ev   = 1'b1;
          code = EV_INCOMING;
        end else if (frame.p_second == CALL_ST_OUT) begin
          ctx_next.call_phase = CPH_DIALING;
          ev   = 1'b1;
          code = EV_OUTGOING;
        end else if (frame.p_second == CALL_ST_ACTIVE) begin
          ctx_next.call_phase = CPH_TALKING;
        end else if (frame.p_second == CALL_ST_END) begin
          ctx_next.call_phase = CPH_IDLE;
          ctx_next.baselined  = 1'b0;
          if (ctx.call_phase == CPH_RINGING) begin
            ev   = 1'b1;
            code = EV_REJECTED;
          end
        end
      end
    end else if (frame.opcode == opcodes.player) begin
      if (frame.has_seven &&
          (frame.p_seventh == PLAY_ST_A || frame.p_seventh == PLAY_ST_B)) begin
        ev   = 1'b1;
        code = EV_PLAYPAUSE;
      end
    end else if (frame.opcode == opcodes.volume) begin
      if (frame.has_one) begin
        if (ctx.call_phase != CPH_IDLE) begin
          ctx_next.last_volume = frame.p_first;
        end else if (!ctx.baselined) begin
          ctx_next.last_volume = frame.p_first;
          ctx_next.baselined   = 1'b1;
        end else if (frame.p_first == VOL_MIN && ctx.last_volume != VOL_MIN) begin
          ctx_next.last_volume = VOL_MIN;
          ev   = 1'b1;
          code = EV_MUTE;
        end else if (frame.p_first > ctx.last_volume) begin
          ctx_next.last_volume = frame.p_first;
          ev   = 1'b1;
          code = EV_VOL_UP;
        end else if (frame.p_first < ctx.last_volume) begin
          ctx_next.last_volume = frame.p_first;
          ev   = 1'b1;
          code = EV_VOL_DOWN;
        end
      end
    end else if (frame.opcode == opcodes.track) begin
      ev   = 1'b1;
      code = EV_TRACK;
    end
  end

endmodule

`default_nettype wire

FILE: sv/serial_event_frame_decoder.sv
// Serial event frame decoder: byte-wise frame parser, checksum check and event mapping.
// Depends on sefd_pkg and sefd_event_map.
//
//  channel  dir  handshake          payload (low bit up)
//  s_*      in   s_tvalid/s_tready  s_tdata[7:0] rx_byte
//  m_*      out  m_tvalid/m_tready  m_tdata: frame_sequence[7:0], frame_opcode[23:8],
//                                   checksum_good[24], event_valid[25], event_code[29:26]
//  cfg_*    in   cfg_we             cfg_addr register index, cfg_data value
//
// One byte per cycle while not stalled; an accepted byte is registered, then parsed.
// Only the checksum byte of a frame makes a result, registered when that byte is parsed.
// The parser stalls only while the result register is full and not taken.
// rst is synchronous; no clearing pass is needed after it.
`default_nettype none

module serial_event_frame_decoder
  import sefd_pkg::*;
#(
  parameter int MAX_PARAMS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [7:0]          s_tdata,   // rx_byte[7:0]
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [31:0]         m_tdata,   // frame_sequence, frame_opcode, checksum_good,
                                         // event_valid, event_code, zero pad
  input  wire                 cfg_we,
  input  wire  [CfgAddrW-1:0] cfg_addr,
  input  wire  [CfgDataW-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_PARAMS + 1);

  typedef enum logic [2:0] {
    PH_SYNC, PH_SEQ, PH_LENL, PH_LENH, PH_OPCL, PH_OPCH, PH_PARAMS, PH_CHK
  } phase_t;

  logic [7:0]  sync_value;
  opcodes_t    opcodes;

  logic        in_vld;
  logic [7:0]  in_byte;
  logic        go;

  phase_t      phase;
  logic [7:0]  sequence_hold;
  logic [7:0]  length_low;
  logic [15:0] params_left;
  logic [15:0] opcode_hold;
  logic [CW-1:0] param_count;
  logic [7:0]  param_first;
  logic [7:0]  param_second;
  logic [7:0]  param_seventh;
  logic [7:0]  sum_acc;
  ctx_t        ctx;

  frame_t      frame;
  logic        ev;
  logic [3:0]  code;
  ctx_t        ctx_next;
  logic        good;
  logic        chk_fire;

  assign go       = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || go;
  assign good     = (in_byte + sum_acc) == 8'd0;
  assign chk_fire = go && (phase == PH_CHK);

  always_comb begin
    frame.opcode    = opcode_hold;
    frame.p_first   = param_first;
    frame.p_second  = param_second;
    frame.p_seventh = param_seventh;
    frame.has_one   = param_count != '0;
    frame.has_two   = param_count >= CW'(2);
    frame.has_seven = param_count >= CW'(7);
  end

  sefd_event_map u_map (
    .frame    (frame),
    .opcodes  (opcodes),
    .ctx      (ctx),
    .ev       (ev),
    .code     (code),
    .ctx_next (ctx_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value     <= 8'd170;
      opcodes        <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SYNC:   sync_value     <= cfg_data[7:0];
        REG_LINK:   opcodes.link   <= cfg_data;
        REG_CALL:   opcodes.call   <= cfg_data;
        REG_PLAYER: opcodes.player <= cfg_data;
        REG_VOLUME: opcodes.volume <= cfg_data;
        REG_TRACK:  opcodes.track  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_SYNC;
      params_left          <= '0;
      param_count          <= '0;
      sum_acc              <= '0;
      ctx.call_phase       <= CPH_IDLE;
      ctx.last_volume      <= VOL_RESET;
      ctx.baselined        <= 1'b0;
      m_tvalid             <= 1'b0;
    end else begin
      if (chk_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (go) begin
        case (phase)
          PH_SYNC: begin
            if (in_byte == sync_value) begin
              param_count <= '0;
              params_left <= '0;
              sum_acc     <= '0;
              phase       <= PH_SEQ;
            end
          end
          PH_SEQ: begin
            sequence_hold <= in_byte;
            sum_acc       <= in_byte;
            phase         <= PH_LENL;
          end
          PH_LENL: begin
            length_low <= in_byte;
            sum_acc    <= sum_acc + in_byte;
            phase      <= PH_LENH;
          end
          PH_LENH: begin
            if (in_byte == 8'd0 && length_low[7:1] == 7'd0) begin
              // length below 2: drop frame
              phase       <= PH_SYNC;
              param_count <= '0;
              params_left <= '0;
              sum_acc     <= '0;
            end else begin
              sum_acc     <= sum_acc + in_byte;
              params_left <= {in_byte, length_low} - 16'd2;
              phase       <= PH_OPCL;
            end
          end
          PH_OPCL: begin
            opcode_hold <= {8'd0, in_byte};
            sum_acc     <= sum_acc + in_byte;
            phase       <= PH_OPCH;
          end
          PH_OPCH: begin
            opcode_hold[15:8] <= in_byte;
            sum_acc           <= sum_acc + in_byte;
            param_count       <= '0;
            phase             <= (params_left == 16'd0) ? PH_CHK : PH_PARAMS;
          end
          PH_PARAMS: begin
            if (param_count < CW'(MAX_PARAMS)) begin
              if (param_count == CW'(0)) begin
                param_first <= in_byte;
              end else if (param_count == CW'(1)) begin
                param_second <= in_byte;
              end else if (param_count == CW'(6)) begin
                param_seventh <= in_byte;
              end
              param_count <= param_count + CW'(1);
            end
            sum_acc     <= sum_acc + in_byte;
            params_left <= params_left - 16'd1;
            if (params_left == 16'd1) begin
              phase <= PH_CHK;
            end
          end
          PH_CHK: begin
            m_tdata  <= {2'b00, (good && ev) ? code : EV_CONNECTED, good && ev, good,
                         opcode_hold, sequence_hold};
            if (good) begin
              ctx <= ctx_next;
            end
            phase       <= PH_SYNC;
            param_count <= '0;
            params_left <= '0;
            sum_acc     <= '0;
          end
          default: phase <= PH_SYNC;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_event_needs_good: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> m_tdata[24])
    else $error("event flagged on a frame with bad checksum");

  a_code_zero_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[25] |-> m_tdata[29:26] == EV_CONNECTED)
    else $error("event code not zero without event");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_vld && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  a_result_from_chk: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && m_tvalid && !$past(m_tvalid && !m_tready) |-> $past(chk_fire))
    else $error("result appeared without a checksum byte");

  a_ctx_only_on_chk: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ctx != $past(ctx) |-> $past(chk_fire && good))
    else $error("call/volume context changed outside a checked frame");
`endif

endmodule

`default_nettype wire

FILE: tb/serial_event_frame_decoder_tb.sv
// Self-checking testbench for serial_event_frame_decoder: byte streams of framed
// messages go in, per-frame results are predicted and compared item by item.
// Depends on sefd_pkg and the serial_event_frame_decoder RTL.
`default_nettype none

module serial_event_frame_decoder_tb
  import sefd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PARAMS = 64;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int DRAIN_LIMIT = 5000;
  localparam logic [7:0] SYNC_RESET = 8'hAA;
  localparam logic [CfgAddrW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_SPARE_B = 3'd7;

  typedef enum logic [2:0] {
    ST_HUNT, ST_SEQ, ST_LEN_LO, ST_LEN_HI, ST_OP_LO, ST_OP_HI, ST_PARM_BYTES, ST_CHECK
  } parse_st_t;

  typedef struct packed {
    logic [7:0]  seq;
    logic [15:0] opcode;
    logic        good;
    logic        ev;
    logic [3:0]  code;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_data;

  always #5 clk = ~clk;

  serial_event_frame_decoder #(.MAX_PARAMS(MAX_PARAMS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // decoder model state
  logic [7:0]  cfg_sync;
  logic [15:0] op_link, op_call, op_player, op_volume, op_track;
  parse_st_t   p_state;
  logic [7:0]  p_seq, p_len_lo, p_cnt, p_first, p_second, p_seventh, p_sum;
  logic [15:0] p_left, p_op;
  logic [7:0]  last_vol;
  logic        vol_based;
  call_phase_t call_st;

  frame_result_t due_results[$];
  logic [7:0] param_buf[$];
  int items_sent = 0;
  int fail_count = 0;
  int results_checked = 0;
  int events_seen = 0;
  int bad_sums = 0;

  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int unsigned sink_wait = 0;

  function automatic void restart_parse();
    p_state = ST_HUNT;
    p_cnt = '0;
    p_left = '0;
    p_sum = '0;
  endfunction

  function automatic bit apply_frame_event(output logic [3:0] code);
    bit was_in;
    code = '0;
    if (p_op == op_link) begin
      if (p_cnt < 1) return 1'b0;
      code = (p_first == PARAM_CONNECTED) ? EV_CONNECTED : EV_DISCONNECTED;
      last_vol = VOL_RESET;
      vol_based = 1'b0;
      call_st = CPH_IDLE;
      return 1'b1;
    end
    if (p_op == op_call) begin
      if (p_cnt < 2) return 1'b0;
      case (p_second)
        CALL_ST_IN: begin
          call_st = CPH_RINGING;
          code = EV_INCOMING;
          return 1'b1;
        end
        CALL_ST_OUT: begin
          call_st = CPH_DIALING;
          code = EV_OUTGOING;
          return 1'b1;
        end
        CALL_ST_ACTIVE: begin
          call_st = CPH_TALKING;
          return 1'b0;
        end
        CALL_ST_END: begin
          was_in = (call_st == CPH_RINGING);
          call_st = CPH_IDLE;
          vol_based = 1'b0;
          code = EV_REJECTED;
          return was_in;
        end
        default: return 1'b0;
      endcase
    end
    if (p_op == op_player) begin
      if (p_cnt < 7) return 1'b0;
      code = EV_PLAYPAUSE;
      return (p_seventh == PLAY_ST_A) || (p_seventh == PLAY_ST_B);
    end
    if (p_op == op_volume) begin
      if (p_cnt < 1) return 1'b0;
      if (call_st != CPH_IDLE || !vol_based) begin
        if (call_st == CPH_IDLE) vol_based = 1'b1;
        last_vol = p_first;
        return 1'b0;
      end
      if (p_first == VOL_MIN && last_vol > VOL_MIN) begin
        last_vol = VOL_MIN;
        code = EV_MUTE;
        return 1'b1;
      end
      if (p_first > last_vol) begin
        last_vol = p_first;
        code = EV_VOL_UP;
        return 1'b1;
      end
      if (p_first < last_vol) begin
        last_vol = p_first;
        code = EV_VOL_DOWN;
        return 1'b1;
      end
      return 1'b0;
    end
    if (p_op == op_track) begin
      code = EV_TRACK;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advances the model by one byte; returns 1 when the byte closes a frame
  function automatic bit parse_rx_byte(input logic [7:0] b, output frame_result_t r);
    logic [15:0] len;
    logic [3:0] code;
    r = '0;
    case (p_state)
      ST_HUNT: begin
        if (b == cfg_sync) begin
          restart_parse();
          p_state = ST_SEQ;
        end
      end
      ST_SEQ: begin
        p_seq = b;
        p_sum = b;
        p_state = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        p_len_lo = b;
        p_sum += b;
        p_state = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len = {b, p_len_lo};
        p_sum += b;
        if (len < 2) restart_parse();
        else begin
          p_left = len - 16'd2;
          p_state = ST_OP_LO;
        end
      end
      ST_OP_LO: begin
        p_op = {8'h00, b};
        p_sum += b;
        p_state = ST_OP_HI;
      end
      ST_OP_HI: begin
        p_op[15:8] = b;
        p_sum += b;
        p_cnt = '0;
        p_state = (p_left == 0) ? ST_CHECK : ST_PARM_BYTES;
      end
      ST_PARM_BYTES: begin
        if (p_cnt < MAX_PARAMS) begin
          if (p_cnt == 0) p_first = b;
          else if (p_cnt == 1) p_second = b;
          else if (p_cnt == 6) p_seventh = b;
          p_cnt++;
        end
        p_sum += b;
        p_left--;
        if (p_left == 0) p_state = ST_CHECK;
      end
      default: begin
        r.seq = p_seq;
        r.opcode = p_op;
        r.good = (b == 8'(8'h00 - p_sum));
        r.ev = r.good ? apply_frame_event(code) : 1'b0;
        r.code = r.ev ? code : 4'd0;
        restart_parse();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(input logic [7:0] b);
    frame_result_t r;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (parse_rx_byte(b, r)) due_results.push_back(r);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC:   cfg_sync = val[7:0];
      REG_LINK:   op_link = val;
      REG_CALL:   op_call = val;
      REG_PLAYER: op_player = val;
      REG_VOLUME: op_volume = val;
      REG_TRACK:  op_track = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sync, input logic [15:0] link, call, player,
                            volume, track);
    write_reg(REG_SYNC, {8'($urandom), sync});  // upper byte must be ignored
    write_reg(REG_LINK, link);
    write_reg(REG_CALL, call);
    write_reg(REG_PLAYER, player);
    write_reg(REG_VOLUME, volume);
    write_reg(REG_TRACK, track);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (due_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // whole frame from param_buf; length follows the buffer size
  task automatic send_frame(input logic [7:0] seq, input logic [15:0] op, input bit corrupt);
    logic [15:0] len;
    logic [7:0] sum, chk;
    len = 16'(param_buf.size() + 2);
    sum = seq + len[7:0] + len[15:8] + op[7:0] + op[15:8];
    foreach (param_buf[i]) sum += param_buf[i];
    chk = 8'(8'h00 - sum);
    if (corrupt) chk ^= 8'($urandom_range(1, 255));
    send_item(cfg_sync);
    send_item(seq);
    send_item(len[7:0]);
    send_item(len[15:8]);
    send_item(op[7:0]);
    send_item(op[15:8]);
    foreach (param_buf[i]) send_item(param_buf[i]);
    send_item(chk);
  endtask

  task automatic send_short_frame(input logic [7:0] seq, input bit len_one);
    send_item(cfg_sync);
    send_item(seq);
    send_item({7'd0, len_one});
    send_item(8'h00);
  endtask

  task automatic directed_frame(input logic [15:0] op, input int n, input int pos,
                                input logic [7:0] val, input bit corrupt = 1'b0);
    param_buf.delete();
    repeat (n) param_buf.push_back(8'($urandom));
    if (pos < n) param_buf[pos] = val;
    send_frame(8'($urandom), op, corrupt);
  endtask

  task automatic send_random_frame();
    int kind, n;
    logic [15:0] op;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) begin
        do b = 8'($urandom); while (b == cfg_sync);
        send_item(b);
      end
    end else if (kind < 13) begin
      send_short_frame(8'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0: op = op_link;
        1: op = op_call;
        2: op = op_player;
        3: op = op_volume;
        4: op = op_track;
        default: op = 16'($urandom);
      endcase
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 72);
      param_buf.delete();
      repeat (n) param_buf.push_back(8'($urandom));
      // small values hit the connect, call, play and equal-volume cases often
      if (n >= 1 && $urandom_range(0, 1)) param_buf[0] = 8'($urandom_range(0, 3));
      if (n >= 2 && $urandom_range(0, 4) < 3) param_buf[1] = 8'($urandom_range(0, 4));
      if (n >= 7 && $urandom_range(0, 4) < 3) param_buf[6] = 8'($urandom_range(0, 3));
      send_frame(8'($urandom), op, $urandom_range(0, 99) < 8);
    end
  endtask

  task automatic test_reset_defaults();
    directed_frame(16'h0000, 1, 0, PARAM_CONNECTED);
    directed_frame(16'h0000, 2, 0, 8'h00);
    directed_frame(16'hBEEF, 3, 0, 8'h00);
    directed_frame(16'h0000, 0, 0, 8'h00);
    wait_drain();
  endtask

  task automatic test_directed_cases();
    set_config(8'h55, 16'h0A01, 16'h0B02, 16'h0C03, 16'h0D04, 16'h0E05);
    directed_frame(op_link, 1, 0, PARAM_CONNECTED);
    directed_frame(op_link, 1, 0, 8'h80);
    directed_frame(op_link, 0, 0, 8'h00);
    directed_frame(op_call, 2, 1, CALL_ST_IN);
    directed_frame(op_call, 2, 1, CALL_ST_END);
    directed_frame(op_call, 3, 1, CALL_ST_OUT);
    directed_frame(op_volume, 1, 0, 8'h30);
    directed_frame(op_call, 2, 1, CALL_ST_ACTIVE);
    directed_frame(op_call, 2, 1, CALL_ST_END);
    directed_frame(op_call, 1, 0, CALL_ST_IN);
    directed_frame(op_player, 7, 6, PLAY_ST_A);
    directed_frame(op_player, 9, 6, PLAY_ST_B);
    directed_frame(op_player, 7, 6, 8'h7F);
    directed_frame(op_player, 6, 0, PLAY_ST_A);
    directed_frame(op_volume, 1, 0, 8'h40);
    directed_frame(op_volume, 2, 0, 8'h50);
    directed_frame(op_volume, 1, 0, 8'h20);
    directed_frame(op_volume, 1, 0, 8'h20);
    directed_frame(op_volume, 1, 0, VOL_MIN);
    directed_frame(op_volume, 1, 0, VOL_RESET);
    directed_frame(op_volume, 0, 0, 8'h00);
    directed_frame(op_track, 0, 0, 8'h00);
    directed_frame(op_track, MAX_PARAMS, 0, 8'h00);
    directed_frame(op_player, 300, 6, PLAY_ST_A);
    directed_frame(16'h7777, 2, 0, 8'h01);
    send_short_frame(8'h00, 1'b0);
    send_short_frame(8'hFF, 1'b1);
    directed_frame(op_link, 1, 0, PARAM_CONNECTED, 1'b1);
    wait_drain();
  endtask

  task automatic test_back_pressure();
    hold_toggle <= ~hold_toggle;
    repeat (20) directed_frame(op_track, 0, 0, 8'h00);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop;
    stop = items_sent + n_items;
    while (items_sent < stop) send_random_frame();
  endtask

  task automatic test_register_extremes();
    wait_drain();
    set_config(8'h00, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h8001);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    test_random_traffic(300);
  endtask

  // result receiver: random stall bursts plus one long hold on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      sink_wait <= LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
      sink_wait <= $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("result with none due: m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (want.ev) events_seen++;
        if (!want.good) bad_sums++;
        if (m_tdata[7:0] !== want.seq) begin
          $error("frame_sequence: expected %0h, got %0h", want.seq, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[23:8] !== want.opcode) begin
          $error("frame_opcode: expected %0h, got %0h", want.opcode, m_tdata[23:8]);
          fail_count++;
        end
        if (m_tdata[24] !== want.good) begin
          $error("checksum_good: expected %0b, got %0b", want.good, m_tdata[24]);
          fail_count++;
        end
        if (m_tdata[25] !== want.ev) begin
          $error("event_valid: expected %0b, got %0b", want.ev, m_tdata[25]);
          fail_count++;
        end
        if (m_tdata[29:26] !== want.code) begin
          $error("event_code: expected %0d, got %0d", want.code, m_tdata[29:26]);
          fail_count++;
        end
        if (m_tdata[31:30] !== 2'b00) begin
          $error("pad: expected 0, got %0b", m_tdata[31:30]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    cfg_sync = SYNC_RESET;
    {op_link, op_call, op_player, op_volume, op_track} = '0;
    restart_parse();
    {p_seq, p_len_lo, p_op, p_first, p_second, p_seventh} = '0;
    last_vol = VOL_RESET;
    vol_based = 1'b0;
    call_st = CPH_IDLE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_cases();
    test_back_pressure();
    test_random_traffic(300);
    test_register_extremes();
    wait_drain();
    set_config(8'hFF, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
    test_random_traffic(200);
    src_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    test_random_traffic(200);
    wait_drain();

    if (due_results.size() != 0) $error("%0d results never arrived", due_results.size());
    $display("Sent %0d bytes; checked %0d frame results, %0d with events, %0d with bad sums.",
             items_sent, results_checked, events_seen, bad_sums);
    $display("Opcode setups covered: reset values, distinct, equal and extreme, random.");
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("serial_event_frame_decoder verification clean");
    end else begin
      $display("serial_event_frame_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("serial_event_frame_decoder verification failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: serial_event_frame_decoder.f
sv/sefd_pkg.sv
sv/sefd_event_map.sv
sv/serial_event_frame_decoder.sv
tb/serial_event_frame_decoder_tb.sv
